>>> rtl/wsoc_pkg.sv
// ----------------------------------------------------------------------------
// wsoc_pkg
// Shared sizes, register indexes and controller states for the sliding-window
// sigma outlier clamp.
// ----------------------------------------------------------------------------
package wsoc_pkg;

    localparam int WINDOW    = 10;
    localparam int X_W       = 16;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int S_W       = X_W + CNT_W;
    localparam int Q_W       = 2 * X_W + CNT_W;
    localparam int V_W       = Q_W + CNT_W;
    localparam int SS_W      = 2 * S_W;
    localparam int NX_W      = X_W + CNT_W;
    localparam int D_W       = (NX_W > S_W) ? NX_W : S_W;
    localparam int DD_W      = 2 * D_W;
    localparam int RR_W      = 16;
    localparam int LHS_W     = DD_W + CNT_W + 6;
    localparam int RN_W      = V_W + CNT_W;
    localparam int RHS_W     = RN_W + RR_W;
    localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int DEN_W     = 2 * CNT_W;
    localparam int DIV_W     = V_W + 8;
    localparam int SQ_W      = DIV_W / 2;
    localparam int MEAN_W    = S_W + 4;
    localparam int STEP_W    = $clog2(DIV_W + 1);
    localparam int CFG_W     = 8;
    localparam int MM_W      = 21;
    localparam int Q4_W      = 20;
    localparam int OFF_W     = CFG_W + Q4_W - 7;
    localparam int TDATA_W   = 64;

    localparam logic [CFG_W-1:0] REJECT_RESET = 8'd20;
    localparam logic [CFG_W-1:0] STEP_RESET   = 8'd12;

    typedef enum logic {
        CFG_REJECT = 1'b0,
        CFG_STEP   = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SQ,
        ST_VAR,
        ST_DEV,
        ST_LHS,
        ST_RN,
        ST_RHS,
        ST_MDIV,
        ST_VLD,
        ST_VDIV,
        ST_QLD,
        ST_SQRT,
        ST_SLD,
        ST_OFF,
        ST_DONE
    } state_t;

endpackage

>>> rtl/window_sigma_outlier_clamp.sv
// ----------------------------------------------------------------------------
// window_sigma_outlier_clamp
// Keeps the last WINDOW range samples, reports window mean and sample sigma,
// and replaces samples lying too far from the mean.
// ----------------------------------------------------------------------------
// One request at a time: a sample is written into the window memory, then the
// memory is swept once (one read per cycle, n reads, n being the window fill),
// followed by a short chain of registered multiplies, a restoring divide for
// the mean (MEAN_W quotient bits), a restoring divide for the variance
// (DIV_W quotient bits), a digit-by-digit square root and the states that
// load the units and form the output. A lone first sample skips the variance
// divide and the root. The two dividers share one unit. A stalled receiver
// holds the finished result until the output register is free.
// A finished result sits in the output register while the next sample is
// taken. With a single sample in the window sigma is zero and the sample
// always passes.
module window_sigma_outlier_clamp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [wsoc_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wsoc_pkg::X_W-1:0]      s_tdata,   // range_cm
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wsoc_pkg::TDATA_W-1:0]  m_tdata,   // corrected_mm, mean_q4, sigma_q4, zeros
    output logic [0:0]                    m_tuser    // is_outlier
);
    import wsoc_pkg::*;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  reject_reg, step_reg;
    logic [CNT_W-1:0]  fill_reg, n_reg, rd_idx_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic signed [MM_W-1:0] last_good_reg;

    logic [X_W-1:0]    win_mem [WINDOW];
    logic [X_W-1:0]    rdata_reg;
    logic              pend_reg;
    logic [X_W-1:0]    x_reg;

    logic [S_W-1:0]    s_reg;
    logic [Q_W-1:0]    q_reg;
    logic [SS_W-1:0]   ss_reg;
    logic [NX_W-1:0]   nx_reg;
    logic [V_W-1:0]    v_reg;
    logic [D_W-1:0]    d_reg;
    logic              above_reg;
    logic [DD_W-1:0]   dd_reg;
    logic [RR_W-1:0]   rr_reg;
    logic [LHS_W-1:0]  lhs_reg;
    logic [RN_W-1:0]   rn_reg;
    logic [RHS_W-1:0]  rhs_reg;
    logic              outlier_reg;
    logic [Q4_W-1:0]   mean_reg, sigma_reg;
    logic [OFF_W-1:0]  off_reg;

    logic [DIV_W-1:0]  num_reg, quo_reg;
    logic [DEN_W-1:0]  den_reg, rem_reg;
    logic [SQ_W-1:0]   res_reg;
    logic [SQ_W+1:0]   srem_reg;
    logic [STEP_W-1:0] cnt_reg;

    logic              m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    logic              accept, rd_en, sum_done, last_step, out_load;

    // Window sweep and arithmetic helpers
    logic [2*X_W-1:0]  sq_w;
    logic [V_W-1:0]    nq_w;
    logic [DEN_W:0]    dv_t;
    logic              dv_ge;
    logic [SQ_W+3:0]   sq_r2, sq_trial;
    logic              sq_ge;
    logic [MEAN_W-1:0] mean_num;
    logic [CFG_W+Q4_W-1:0] off_prod;
    logic signed [MM_W+1:0] adj_w;
    logic signed [MM_W-1:0] corr_w;
    logic [MM_W-1:0]   pass_w;

    assign accept    = s_tvalid && s_tready;
    assign sum_done  = (rd_idx_reg == n_reg) && !pend_reg;
    assign last_step = (cnt_reg == STEP_W'(1));
    assign out_load  = !m_tvalid_reg || m_tready;

    assign sq_w     = rdata_reg * rdata_reg;
    assign nq_w     = V_W'(q_reg) * V_W'(n_reg);
    assign mean_num = {s_reg, 4'b0} + MEAN_W'(n_reg >> 1);

    assign dv_t  = {rem_reg, num_reg[DIV_W-1]};
    assign dv_ge = (dv_t >= {1'b0, den_reg});

    assign sq_r2    = {srem_reg, num_reg[DIV_W-1 -: 2]};
    assign sq_trial = {2'b00, res_reg, 2'b01};
    assign sq_ge    = (sq_r2 >= sq_trial);

    assign off_prod = step_reg * sigma_reg + (CFG_W+Q4_W)'(64);
    assign pass_w   = MM_W'(x_reg * 4'd10);

    always_comb begin
        if (above_reg) begin
            adj_w = (MM_W+2)'(last_good_reg) + $signed({2'b00, off_reg});
        end else begin
            adj_w = (MM_W+2)'(last_good_reg) - $signed({2'b00, off_reg});
        end
        if (!outlier_reg) begin
            corr_w = $signed(pass_w);
        end else if (adj_w > (MM_W+2)'(2 ** (MM_W - 1) - 1)) begin
            corr_w = {1'b0, {(MM_W-1){1'b1}}};
        end else if (adj_w < -((MM_W+2)'(2 ** (MM_W - 1)))) begin
            corr_w = {1'b1, {(MM_W-1){1'b0}}};
        end else begin
            corr_w = MM_W'(adj_w);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_SUM;
            ST_SUM:  if (sum_done) state_next = ST_SQ;
            ST_SQ:   state_next = ST_VAR;
            ST_VAR:  state_next = ST_DEV;
            ST_DEV:  state_next = ST_LHS;
            ST_LHS:  state_next = ST_RN;
            ST_RN:   state_next = ST_RHS;
            ST_RHS:  state_next = ST_MDIV;
            ST_MDIV: if (last_step) state_next = ST_VLD;
            ST_VLD:  state_next = (n_reg == CNT_W'(1)) ? ST_OFF : ST_VDIV;
            ST_VDIV: if (last_step) state_next = ST_QLD;
            ST_QLD:  state_next = ST_SQRT;
            ST_SQRT: if (last_step) state_next = ST_SLD;
            ST_SLD:  state_next = ST_OFF;
            ST_OFF:  state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        rd_en    = (state_reg == ST_SUM) && (rd_idx_reg != n_reg);
    end

    // Window memory: write on accept, one sweep read per cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_mem[slot_reg] <= s_tdata;
        end
        if (rd_en) begin
            rdata_reg <= win_mem[rd_idx_reg[SLOT_W-1:0]];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            reject_reg    <= REJECT_RESET;
            step_reg      <= STEP_RESET;
            fill_reg      <= '0;
            slot_reg      <= '0;
            last_good_reg <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_REJECT: reject_reg <= cfg_wdata;
                    CFG_STEP:   step_reg   <= cfg_wdata;
                    default:    ;
                endcase
            end
            if (accept) begin
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                if (fill_reg != CNT_W'(WINDOW)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (state_reg == ST_DONE && out_load) begin
                m_tvalid_reg <= 1'b1;
                if (!outlier_reg) begin
                    last_good_reg <= corr_w;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                x_reg      <= s_tdata;
                n_reg      <= (fill_reg == CNT_W'(WINDOW)) ? fill_reg : fill_reg + 1'b1;
                rd_idx_reg <= '0;
                s_reg      <= '0;
                q_reg      <= '0;
            end
            ST_SUM: begin
                if (rd_en) begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (pend_reg) begin
                    s_reg <= s_reg + S_W'(rdata_reg);
                    q_reg <= q_reg + Q_W'(sq_w);
                end
            end
            ST_SQ: begin
                ss_reg <= s_reg * s_reg;
                nx_reg <= NX_W'(x_reg) * NX_W'(n_reg);
            end
            ST_VAR: begin
                v_reg     <= nq_w - V_W'(ss_reg);
                above_reg <= (D_W'(nx_reg) > D_W'(s_reg));
                d_reg     <= (D_W'(nx_reg) >= D_W'(s_reg)) ? D_W'(nx_reg) - D_W'(s_reg)
                                                           : D_W'(s_reg) - D_W'(nx_reg);
            end
            ST_DEV: begin
                dd_reg <= d_reg * d_reg;
                rr_reg <= reject_reg * reject_reg;
            end
            ST_LHS: begin
                lhs_reg <= {(LHS_W-6)'(dd_reg * (n_reg - 1'b1)), 6'b0};
            end
            ST_RN: begin
                rn_reg <= RN_W'(v_reg) * RN_W'(n_reg);
            end
            ST_RHS: begin
                rhs_reg <= RHS_W'(rn_reg) * RHS_W'(rr_reg);
                num_reg <= {mean_num, (DIV_W-MEAN_W)'(0)};
                den_reg <= DEN_W'(n_reg);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= STEP_W'(MEAN_W);
            end
            ST_MDIV, ST_VDIV: begin
                rem_reg <= dv_ge ? DEN_W'(dv_t - {1'b0, den_reg}) : DEN_W'(dv_t);
                quo_reg <= {quo_reg[DIV_W-2:0], dv_ge};
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_VLD: begin
                mean_reg    <= (quo_reg[MEAN_W-1:0] > MEAN_W'(2 ** Q4_W - 1))
                               ? '1 : quo_reg[Q4_W-1:0];
                outlier_reg <= (n_reg != CNT_W'(1))
                               && (CMP_W'(lhs_reg) > CMP_W'(rhs_reg));
                sigma_reg   <= '0;
                num_reg     <= {v_reg, 8'b0};
                den_reg     <= DEN_W'(n_reg) * DEN_W'(n_reg - 1'b1);
                rem_reg     <= '0;
                quo_reg     <= '0;
                cnt_reg     <= STEP_W'(DIV_W);
            end
            ST_QLD: begin
                num_reg  <= quo_reg;
                res_reg  <= '0;
                srem_reg <= '0;
                cnt_reg  <= STEP_W'(SQ_W);
            end
            ST_SQRT: begin
                srem_reg <= sq_ge ? (SQ_W+2)'(sq_r2 - sq_trial) : (SQ_W+2)'(sq_r2);
                res_reg  <= {res_reg[SQ_W-2:0], sq_ge};
                num_reg  <= num_reg << 2;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            ST_SLD: begin
                sigma_reg <= (res_reg > SQ_W'(2 ** Q4_W - 1)) ? '1 : res_reg[Q4_W-1:0];
            end
            ST_OFF: begin
                off_reg <= off_prod[CFG_W+Q4_W-1:7];
            end
            ST_DONE: begin
                if (out_load) begin
                    m_tdata_reg <= {(TDATA_W-MM_W-2*Q4_W)'(0), sigma_reg, mean_reg, corr_w};
                    m_tuser_reg <= outlier_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Checks
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in progress");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW) && slot_reg < SLOT_W'(WINDOW))
        else $error("window fill or slot out of range");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SUM |-> rd_idx_reg <= n_reg)
        else $error("window sweep ran past the fill");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the completion state");

endmodule

>>> bench/wsoc_checker.sv
// ----------------------------------------------------------------------------
// wsoc_checker
// Watches both stream channels and the register port of the outlier clamp,
// keeps its own window of range samples, forms mean, sigma and the corrected
// range per request and compares every field of each result.
// ----------------------------------------------------------------------------
module wsoc_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_addr,
    input  logic [wsoc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [wsoc_pkg::X_W-1:0]            s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [wsoc_pkg::TDATA_W-1:0]        m_tdata,
    input  logic [0:0]                          m_tuser,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  outlier_seen
);
    import wsoc_pkg::*;

    typedef struct packed {
        logic signed [20:0] corrected_mm;
        logic [19:0]        mean_q4;
        logic [19:0]        sigma_q4;
        logic               is_outlier;
    } clamp_res_t;

    clamp_res_t         expected_q[$];
    logic [15:0]        samples[WINDOW];
    int unsigned        fill;
    int unsigned        slot;
    longint             last_good;
    logic [7:0]         reject_r;
    logic [7:0]         step_r;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clip21(longint v);
        if (v > 1048575) return 1048575;
        if (v < -1048576) return -1048576;
        return v;
    endfunction

    // Advance the window and form the mean, sigma and corrected range for one sample.
    function automatic clamp_res_t clamp_sample(logic [15:0] x);
        clamp_res_t      r;
        longint unsigned n, s, q, v, mq, sq, nx, d, lhs, rhs, rr, off;
        longint          cm;
        bit              outl;
        s = 0; q = 0; sq = 0; outl = 0;
        samples[slot] = x;
        slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
        if (fill < WINDOW) fill++;
        n = fill;
        for (int i = 0; i < fill; i++) begin
            s += samples[i];
            q += longint'(samples[i]) * samples[i];
        end
        mq = (s * 16 + n / 2) / n;
        if (mq > 1048575) mq = 1048575;
        v = n * q - s * s;
        if (n > 1) begin
            nx = n * x;
            d = (nx >= s) ? nx - s : s - nx;
            lhs = 64 * (n - 1) * d * d;
            rr = reject_r;
            rhs = rr * rr * n * v;
            sq = int_sqrt((v * 256) / (n * (n - 1)));
            outl = lhs > rhs;
            if (outl) begin
                off = (step_r * sq + 64) >> 7;
                cm = (nx > s) ? clip21(last_good + longint'(off))
                              : clip21(last_good - longint'(off));
            end
        end
        if (sq > 1048575) sq = 1048575;
        if (!outl) begin
            cm = longint'(x) * 10;
            last_good = cm;
        end
        r.corrected_mm = cm[20:0];
        r.mean_q4      = mq[19:0];
        r.sigma_q4     = sq[19:0];
        r.is_outlier   = outl;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        clamp_res_t want;
        clamp_res_t got;
        if (!aresetn) begin
            expected_q.delete();
            fill       = 0;
            slot       = 0;
            last_good  = 0;
            reject_r   <= REJECT_RESET;
            step_r     <= STEP_RESET;
            fail_count <= 0;
            outlier_seen <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_REJECT) reject_r <= cfg_wdata;
                else                        step_r   <= cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                got.corrected_mm = m_tdata[20:0];
                got.mean_q4      = m_tdata[40:21];
                got.sigma_q4     = m_tdata[60:41];
                got.is_outlier   = m_tuser[0];
                if (got.is_outlier) outlier_seen <= outlier_seen + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected: %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch exp mm=%0d mean=%0d sig=%0d out=%0b",
                                 $time, want.corrected_mm, want.mean_q4,
                                 want.sigma_q4, want.is_outlier);
                        $display("%0t:          got mm=%0d mean=%0d sig=%0d out=%0b",
                                 $time, got.corrected_mm, got.mean_q4,
                                 got.sigma_q4, got.is_outlier);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.insert(expected_q.size(), clamp_sample(s_tdata));
        end
    end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives range samples and register writes into the outlier clamp across
// several idling phases and register settings; the checker judges results.
// ----------------------------------------------------------------------------
module testbench;
    import wsoc_pkg::*;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_we = 0;
    logic                 cfg_addr = 0;
    logic [CFG_W-1:0]     cfg_wdata = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [X_W-1:0]       s_tdata = 0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;
    int                   fail_count;
    int                   pending;
    int                   outlier_seen;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    window_sigma_outlier_clamp dut (.*);

    wsoc_checker u_checker (.*);

    // Receiver stalls at random according to the current phase.
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Lower tvalid between requests, with random idling set by send_idle_pct.
    task automatic send_sample(logic [15:0] x);
        do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        s_tvalid <= 1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 0;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        cfg_we    <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 0;
        @(posedge aclk);
    endtask

    // Mostly a steady range with small noise, with occasional spikes.
    function automatic logic [15:0] pick_sample(int base);
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'(base + $urandom_range(40) - 20);
        endcase
    endfunction

    initial begin
        int base;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // single sample, equal samples, extremes, spikes both sides
        send_sample(16'd500);
        repeat (9) send_sample(16'd500);
        send_sample(16'd500);
        send_sample(16'hFFFF);
        send_sample(16'd0);
        repeat (3) send_sample(16'd510);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        repeat (5) send_sample(16'hFFFF);
        send_sample(16'h0000);
        drain();
        write_reg(CFG_REJECT, 8'd0);
        write_reg(CFG_STEP, 8'd0);
        send_sample(16'd700);
        send_sample(16'd701);
        send_sample(16'd700);
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case (ph)
                0: begin write_reg(CFG_REJECT, 8'd1);   write_reg(CFG_STEP, 8'd255); end
                1: begin write_reg(CFG_REJECT, 8'd255); write_reg(CFG_STEP, 8'd0);   end
                2, 3: begin
                    write_reg(CFG_REJECT, 8'd20); write_reg(CFG_STEP, 8'd12);
                end
                default: begin
                    write_reg(CFG_REJECT, 8'($urandom_range(255)));
                    write_reg(CFG_STEP, 8'($urandom));
                end
            endcase
            base = $urandom;
            for (int i = 0; i < 250; i++) begin
                if ($urandom_range(49) == 0) base = $urandom;
                send_sample(pick_sample(base));
                if ($urandom_range(15) == 0) repeat ($urandom_range(30)) @(posedge aclk);
            end
            drain();
        end
        $display("Covered %0d samples over eight idling and register phases,", 2000);
        $display("with %0d outliers replaced.", outlier_seen);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
rtl/wsoc_pkg.sv
rtl/window_sigma_outlier_clamp.sv
bench/wsoc_checker.sv
bench/testbench.sv
